// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file fvc_checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/fvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvc_pkg
// Types, constants and saturation helpers for the formation velocity
// consensus controller.
// ----------------------------------------------------------------------------
package fvc_pkg;

  // Agents with an index at or above this are ignored
  localparam int MaxAgents = 16;

  localparam int AccW   = 40;   // neighbour sums, Q24.16
  localparam int VaW    = 48;   // virtual acceleration, Q32.16
  localparam int ErrW   = 42;   // consensus error before gain
  localparam int CmdW   = 52;   // command before final clip
  localparam int MulAW  = 49;   // shared multiplier, signed operand
  localparam int MulBW  = 16;   // shared multiplier, unsigned operand
  localparam int ProdW  = MulAW + MulBW + 1;
  localparam int CntW   = 5;

  localparam logic [CntW-1:0]  CntMax     = 5'd31;
  localparam logic [MulBW-1:0] GainNeigh  = 16'd19661;  // 0.3 in Q0.16
  localparam logic [15:0]      TimeStepRst = 16'd655;
  localparam logic signed [CmdW-1:0] ZBias = 52'sd32768;  // 0.5 in Q16.16

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SELF_INDEX     = 2'd0,
    CFG_NEIGHBOUR_MASK = 2'd1,
    CFG_TIME_STEP      = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } ctrl_state_e;

  // Round-end sequence: each step but the last issues one product; each but the first retires the previous
  typedef enum logic [3:0] {
    STEP_CNT_SX  = 4'd0,
    STEP_CNT_SY  = 4'd1,
    STEP_GAIN_EX = 4'd2,
    STEP_GAIN_EY = 4'd3,
    STEP_VA_X    = 4'd4,
    STEP_VA_Y    = 4'd5,
    STEP_VA_Z    = 4'd6,
    STEP_CNT_VX  = 4'd7,
    STEP_CNT_VY  = 4'd8,
    STEP_CNT_VZ  = 4'd9,
    STEP_FINAL   = 4'd10
  } step_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
  } agent_t;

  typedef struct packed {
    logic [3:0] agent_index;
    agent_t     st;
  } item_t;

  typedef struct packed {
    logic signed [31:0] cmd_vel_x;
    logic signed [31:0] cmd_vel_y;
    logic signed [31:0] cmd_vel_z;
    logic               saturated;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  item_en;   // accepted item: latch and accumulate
    logic  step_en;   // run one sequence step
    step_e step;
    logic  out_load;  // capture the result
  } dp_cmd_t;

  typedef struct packed {
    logic                   clip;
    logic signed [AccW-1:0] val;
  } sat40_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat32_t;

  function automatic sat40_t sat40(logic signed [AccW:0] v);
    sat40_t r;
    r.clip = (v[AccW] != v[AccW-1]);
    r.val  = r.clip ? {v[AccW], {(AccW-1){~v[AccW]}}} : v[AccW-1:0];
    return r;
  endfunction

  function automatic sat32_t sat32(logic signed [CmdW-1:0] v);
    sat32_t r;
    r.clip = (v[CmdW-1:31] != {(CmdW-31){v[CmdW-1]}});
    r.val  = r.clip ? {v[CmdW-1], {31{~v[CmdW-1]}}} : v[31:0];
    return r;
  endfunction

  // Round half up from Q.32 to Q.16
  function automatic logic signed [CmdW-1:0] round16(logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    logic signed [ProdW-1:0] s;
    t = p + ProdW'(32768);
    s = t >>> 16;
    return s[CmdW-1:0];
  endfunction

endpackage

// ----- hw/rtl/fvc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvc_ctrl
// Sequencer: accepts agent items and steps the datapath through the
// round-end calculation, holding the result until it is taken.
// ----------------------------------------------------------------------------
module fvc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  input  logic             out_ready_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output fvc_pkg::dp_cmd_t cmd_o
);
  import fvc_pkg::*;

  ctrl_state_e state_q, state_d;
  step_e       step_q, step_d;
  logic        out_valid_q, out_valid_d;
  logic        can_load;

  // Result slot is free or empties this cycle
  assign can_load = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_CNT_SX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    in_ready_o    = 1'b0;
    cmd_o.item_en = 1'b0;
    cmd_o.step_en = 1'b0;
    cmd_o.step    = step_q;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_en = 1'b1;
          if (in_last_i) begin
            state_d = ST_CALC;
            step_d  = STEP_CNT_SX;
          end
        end
      end
      ST_CALC: begin
        if (step_q == STEP_FINAL) begin
          // Hold the last step until the result slot is free
          if (can_load) begin
            cmd_o.step_en  = 1'b1;
            cmd_o.out_load = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.step_en = 1'b1;
          step_d        = step_e'(4'(step_q) + 4'd1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/fvc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvc_dpath
// Datapath: configuration registers, latched self and leader state,
// neighbour accumulators, one shared multiplier and the result register.
// ----------------------------------------------------------------------------
module fvc_dpath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  input  fvc_pkg::item_t   item_i,
  input  fvc_pkg::dp_cmd_t cmd_i,
  output fvc_pkg::result_t result_o
);
  import fvc_pkg::*;

  logic [3:0]  self_index_q;
  logic [15:0] neighbour_mask_q;
  logic [15:0] time_step_q;

  agent_t self_q, leader_q;

  logic signed [AccW-1:0] psum_x_q, psum_y_q;
  logic signed [AccW-1:0] vsum_x_q, vsum_y_q, vsum_z_q;
  logic [CntW-1:0]        count_q;
  logic                   clip_q;

  logic signed [VaW-1:0]  va_x_q, va_y_q, va_z_q;
  logic signed [ErrW-1:0] ex_q, ey_q;
  logic signed [CmdW-1:0] cx_q, cy_q, cz_q;

  logic signed [MulAW-1:0] mul_a;
  logic [MulBW-1:0]        mul_b;
  logic signed [ProdW-1:0] prod_d, prod_q;

  result_t res_q;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_index_q     <= '0;
      neighbour_mask_q <= '0;
      time_step_q      <= TimeStepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SELF_INDEX:     self_index_q     <= cfg_data_i[3:0];
        CFG_NEIGHBOUR_MASK: neighbour_mask_q <= cfg_data_i;
        CFG_TIME_STEP:      time_step_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Item decode and accumulation
  // --------------------------------------------------------------------------
  logic in_range, is_self, is_leader, is_neigh;
  logic signed [32:0] n_px, n_py;
  sat40_t ps_x, ps_y, vs_x, vs_y, vs_z;

  assign in_range  = int'(item_i.agent_index) < MaxAgents;
  assign is_self   = in_range && (item_i.agent_index == self_index_q);
  assign is_leader = in_range && (item_i.agent_index == 4'd0);
  assign is_neigh  = in_range && (item_i.agent_index != 4'd0)
                     && neighbour_mask_q[item_i.agent_index];

  assign n_px = 33'(item_i.st.pos_x) - 33'(item_i.st.off_x);
  assign n_py = 33'(item_i.st.pos_y) - 33'(item_i.st.off_y);
  assign ps_x = sat40(41'(psum_x_q) + 41'(n_px));
  assign ps_y = sat40(41'(psum_y_q) + 41'(n_py));
  assign vs_x = sat40(41'(vsum_x_q) + 41'(item_i.st.vel_x));
  assign vs_y = sat40(41'(vsum_y_q) + 41'(item_i.st.vel_y));
  assign vs_z = sat40(41'(vsum_z_q) + 41'(item_i.st.vel_z));

  // --------------------------------------------------------------------------
  // Derived self and leader terms
  // --------------------------------------------------------------------------
  logic signed [32:0] s_x, s_y, l_x, l_y, d_z;
  logic signed [33:0] d_x, d_y;
  logic signed [32:0] dv_x, dv_y, dv_z;
  logic signed [38:0] gv_x, gv_y, gv_z;

  assign s_x  = 33'(self_q.pos_x) - 33'(self_q.off_x);
  assign s_y  = 33'(self_q.pos_y) - 33'(self_q.off_y);
  assign l_x  = 33'(leader_q.pos_x) - 33'(leader_q.off_x);
  assign l_y  = 33'(leader_q.pos_y) - 33'(leader_q.off_y);
  assign d_x  = 34'(l_x) - 34'(s_x);
  assign d_y  = 34'(l_y) - 34'(s_y);
  assign d_z  = 33'(leader_q.pos_z) - 33'(self_q.pos_z);
  assign dv_x = 33'(leader_q.vel_x) - 33'(self_q.vel_x);
  assign dv_y = 33'(leader_q.vel_y) - 33'(self_q.vel_y);
  assign dv_z = 33'(leader_q.vel_z) - 33'(self_q.vel_z);
  // Leader velocity gain of 20 as 16 + 4
  assign gv_x = (39'(dv_x) <<< 4) + (39'(dv_x) <<< 2);
  assign gv_y = (39'(dv_y) <<< 4) + (39'(dv_y) <<< 2);
  assign gv_z = (39'(dv_z) <<< 4) + (39'(dv_z) <<< 2);

  // --------------------------------------------------------------------------
  // Shared multiplier operand select
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.step)
      STEP_CNT_SX:  begin mul_a = 49'(s_x);          mul_b = 16'(count_q); end
      STEP_CNT_SY:  begin mul_a = 49'(s_y);          mul_b = 16'(count_q); end
      STEP_GAIN_EX: begin mul_a = 49'(ex_q);         mul_b = GainNeigh;    end
      STEP_GAIN_EY: begin mul_a = 49'(ey_q);         mul_b = GainNeigh;    end
      STEP_VA_X:    begin mul_a = 49'(va_x_q);       mul_b = time_step_q;  end
      STEP_VA_Y:    begin mul_a = 49'(va_y_q);       mul_b = time_step_q;  end
      STEP_VA_Z:    begin mul_a = 49'(va_z_q);       mul_b = time_step_q;  end
      STEP_CNT_VX:  begin mul_a = 49'(self_q.vel_x); mul_b = 16'(count_q); end
      STEP_CNT_VY:  begin mul_a = 49'(self_q.vel_y); mul_b = 16'(count_q); end
      STEP_CNT_VZ:  begin mul_a = 49'(self_q.vel_z); mul_b = 16'(count_q); end
      default: ;
    endcase
  end

  assign prod_d = mul_a * $signed({1'b0, mul_b});

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_en) begin
      prod_q <= prod_d;
    end
  end

  // --------------------------------------------------------------------------
  // Retire the previous step's product
  // --------------------------------------------------------------------------
  logic signed [CmdW-1:0] prod_r;
  logic signed [ErrW-1:0] prod_e;
  logic signed [VaW-1:0]  va_new;
  logic signed [AccW-1:0] vsum_sel;
  logic signed [38:0]     gv_sel;
  sat32_t                 o_x, o_y, o_z;

  assign prod_r = round16(prod_q);
  assign prod_e = prod_q[ErrW-1:0];

  // Velocity term for the axis retired this step
  always_comb begin
    vsum_sel = vsum_x_q;
    gv_sel   = gv_x;
    unique case (cmd_i.step)
      STEP_CNT_VZ: begin vsum_sel = vsum_y_q; gv_sel = gv_y; end
      STEP_FINAL:  begin vsum_sel = vsum_z_q; gv_sel = gv_z; end
      default: ;
    endcase
  end

  // Stays well inside 48 bits, so the virtual acceleration never clips
  assign va_new = 48'(vsum_sel) - 48'(prod_e) + 48'(gv_sel);

  assign o_x = sat32(cx_q);
  assign o_y = sat32(cy_q);
  assign o_z = sat32(cz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_x_q <= '0;
      va_y_q <= '0;
      va_z_q <= '0;
    end else if (cmd_i.step_en) begin
      unique case (cmd_i.step)
        STEP_CNT_VY: va_x_q <= va_new;
        STEP_CNT_VZ: va_y_q <= va_new;
        STEP_FINAL:  va_z_q <= va_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_en) begin
      unique case (cmd_i.step)
        STEP_CNT_SY:  ex_q <= 42'(psum_x_q) - prod_e;
        STEP_GAIN_EX: ey_q <= 42'(psum_y_q) - prod_e;
        STEP_GAIN_EY: cx_q <= prod_r + 52'(d_x);
        STEP_VA_X:    cy_q <= prod_r + 52'(d_y);
        STEP_VA_Y:    cx_q <= cx_q + prod_r;
        STEP_VA_Z:    cy_q <= cy_q + prod_r;
        STEP_CNT_VX:  cz_q <= prod_r + 52'(d_z) + ZBias;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Latched states, accumulators and clip flag
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q   <= '0;
      leader_q <= '0;
      psum_x_q <= '0;
      psum_y_q <= '0;
      vsum_x_q <= '0;
      vsum_y_q <= '0;
      vsum_z_q <= '0;
      count_q  <= '0;
      clip_q   <= 1'b0;
    end else if (cmd_i.item_en) begin
      if (is_self) begin
        self_q <= item_i.st;
      end
      if (is_leader) begin
        leader_q <= item_i.st;
      end
      if (is_neigh) begin
        psum_x_q <= ps_x.val;
        psum_y_q <= ps_y.val;
        vsum_x_q <= vs_x.val;
        vsum_y_q <= vs_y.val;
        vsum_z_q <= vs_z.val;
        if (count_q != CntMax) begin
          count_q <= count_q + 5'd1;
        end
        if (ps_x.clip || ps_y.clip || vs_x.clip || vs_y.clip || vs_z.clip
            || (count_q == CntMax)) begin
          clip_q <= 1'b1;
        end
      end
    end else if (cmd_i.step_en && (cmd_i.step == STEP_FINAL)) begin
      // Round closed: clear for the next one
      psum_x_q <= '0;
      psum_y_q <= '0;
      vsum_x_q <= '0;
      vsum_y_q <= '0;
      vsum_z_q <= '0;
      count_q  <= '0;
      clip_q   <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q.cmd_vel_x <= o_x.val;
      res_q.cmd_vel_y <= o_y.val;
      res_q.cmd_vel_z <= o_z.val;
      res_q.saturated <= clip_q || o_x.clip || o_y.clip || o_z.clip;
    end
  end

  assign result_o = res_q;

endmodule

// ----- hw/rtl/formation_velocity_consensus.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// formation_velocity_consensus
// Leader-follower formation controller with neighbour consensus: streams
// one control round of agent states and returns one velocity command.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         agent state, tlast = round end
//  m_axis    out        velocity command, tuser = saturated
//  cfg       in         register index and write data
//
//  An item with tlast starts eleven steps of the shared 49 x 17 bit
//  multiplier. The last step waits while an earlier command is still
//  not taken. Reset clears the configuration, latched states, sums and
//  control state at once; there is no clearing pass. The product, error,
//  command and result registers are not reset.
// ----------------------------------------------------------------------------
module formation_velocity_consensus (
  input  logic         clk_i,
  input  logic         rst_ni,
  // agent_index[3:0], pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
  // offset_x, offset_y (32 bits each), zero pad
  input  logic [263:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tlast,
  output logic         s_axis_tready,
  // cmd_vel_x[31:0], cmd_vel_y[63:32], cmd_vel_z[95:64]
  output logic [95:0]  m_axis_tdata,
  // saturated
  output logic         m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);
  import fvc_pkg::*;

  item_t   item;
  dp_cmd_t cmd;
  result_t result;

  // Unpack the input transaction
  always_comb begin
    item.agent_index = s_axis_tdata[3:0];
    item.st.pos_x    = s_axis_tdata[35:4];
    item.st.pos_y    = s_axis_tdata[67:36];
    item.st.pos_z    = s_axis_tdata[99:68];
    item.st.vel_x    = s_axis_tdata[131:100];
    item.st.vel_y    = s_axis_tdata[163:132];
    item.st.vel_z    = s_axis_tdata[195:164];
    item.st.off_x    = s_axis_tdata[227:196];
    item.st.off_y    = s_axis_tdata[259:228];
  end

  assign cfg_ready_o = 1'b1;

  fvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  fvc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .result_o    (result)
  );

  // Pack the output transaction
  assign m_axis_tdata = {result.cmd_vel_z, result.cmd_vel_y, result.cmd_vel_x};
  assign m_axis_tuser = result.saturated;

endmodule

// ----- hw/rtl/fvc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvc_checker
// Port-level checks on round sequencing and result hand-over.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fvc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  // A waiting result holds until taken
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Closing a round stops intake while the command is worked out
  `ASSERT_NEXT(a_last_blocks, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

  // Intake only stops after a round-end transaction
  `ASSERT_IMPL(a_stop_cause, $fell(s_axis_tready), $past(s_axis_tvalid && s_axis_tlast))

  // A new result appears exactly as intake reopens
  `ASSERT_IMPL(a_result_at_end, $rose(m_axis_tvalid), s_axis_tready && $past(!s_axis_tready))

endmodule

bind formation_velocity_consensus fvc_checker u_fvc_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the formation velocity consensus controller.
// Streams control rounds of agent states under random source and sink stalls
// and compares every velocity command with a cycle-free model of the
// controller.
// ----------------------------------------------------------------------------
module testbench;
  import fvc_pkg::*;

  // Agent state as it sits on s_axis_tdata, lowest field last
  typedef struct packed {
    logic [3:0]         pad;
    logic signed [31:0] off_y;
    logic signed [31:0] off_x;
    logic signed [31:0] vel_z;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic [3:0]         agent_index;
  } agent_word_t;

  typedef struct packed {
    logic        last;
    agent_word_t word;
  } feed_entry_t;

  // Velocity command as it sits on m_axis_tdata
  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vel_cmd_t;

  typedef struct packed {
    logic     sat;
    vel_cmd_t cmd;
  } cmd_result_t;

  typedef enum {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_e;
  typedef enum {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_ZERO, FILL_RUNAWAY} fill_e;

  localparam logic [1:0]  CfgNoReg   = 2'd3;   // index past the register list
  localparam int          CountLimit = 31;
  localparam int          LeaderGain = 20;
  localparam longint      NeighGain  = 19661;  // 0.3 in Q0.16
  localparam longint      HalfQ16    = 32768;
  localparam longint      Lim32      = longint'(1) << 31;
  localparam longint      Lim40      = longint'(1) << 39;
  localparam longint      Lim48      = longint'(1) << 47;
  localparam logic [31:0] QMax       = 32'h7fff_ffff;
  localparam logic [31:0] QMin       = 32'h8000_0000;
  localparam int          LongHold   = 400;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [263:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;

  // Model copy of registers and controller state
  logic [3:0]   cfg_self = 4'd0;
  logic [15:0]  cfg_mask = 16'd0;
  logic [15:0]  cfg_dt = TimeStepRst;
  longint       virt_accel [3];
  longint       self_st [8];
  longint       lead_st [8];
  longint       pos_sum [2];
  longint       vel_sum [3];
  int           nbr_count;
  logic         round_clipped;

  feed_entry_t  agent_feed [$];
  cmd_result_t  pending_cmds [$];
  int           queued_count = 0;
  int           accepted_count = 0;
  int           mismatches = 0;
  idle_mode_e   idle_level = IDLE_LIGHT;
  logic         long_hold_req = 1'b0;
  logic         long_hold_taken = 1'b0;
  int           tx_gap = 0;
  int           rx_wait = 0;
  feed_entry_t  tx_next;
  cmd_result_t  rx_want;
  vel_cmd_t     rx_got;

  formation_velocity_consensus uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Clip to [-lim, lim) and note the clip for this round
  function automatic longint clip_to(longint v, longint lim);
    if (v >= lim) begin
      round_clipped = 1'b1;
      return lim - 1;
    end
    if (v < -lim) begin
      round_clipped = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  // Q.32 to Q.16, round half up
  function automatic longint round_q16(longint v);
    return (v + HalfQ16) >>> 16;
  endfunction

  // Latch and accumulate one agent; on round end queue the expected command
  function automatic void step_formation(agent_word_t w, logic last);
    longint      f [8];
    longint      cmd [3];
    longint      k;
    longint      dt;
    longint      s;
    longint      l;
    longint      e;
    longint      vs;
    cmd_result_t r;
    f[0] = longint'(w.pos_x);
    f[1] = longint'(w.pos_y);
    f[2] = longint'(w.pos_z);
    f[3] = longint'(w.vel_x);
    f[4] = longint'(w.vel_y);
    f[5] = longint'(w.vel_z);
    f[6] = longint'(w.off_x);
    f[7] = longint'(w.off_y);
    if (w.agent_index == cfg_self) self_st = f;
    if (w.agent_index == 4'd0) lead_st = f;
    if (w.agent_index != 4'd0 && cfg_mask[w.agent_index]) begin
      for (int i = 0; i < 2; i++) pos_sum[i] = clip_to(pos_sum[i] + f[i] - f[6 + i], Lim40);
      for (int i = 0; i < 3; i++) vel_sum[i] = clip_to(vel_sum[i] + f[3 + i], Lim40);
      if (nbr_count < CountLimit) nbr_count++;
      else round_clipped = 1'b1;
    end
    if (!last) return;

    k  = longint'(nbr_count);
    dt = longint'({48'd0, cfg_dt});
    for (int i = 0; i < 3; i++) cmd[i] = round_q16(virt_accel[i] * dt);
    for (int i = 0; i < 2; i++) begin
      s = self_st[i] - self_st[6 + i];
      l = lead_st[i] - lead_st[6 + i];
      e = pos_sum[i] - k * s;
      cmd[i] += round_q16(e * NeighGain) + (l - s);
    end
    cmd[2] += lead_st[2] - self_st[2] + HalfQ16;
    r.cmd.x = 32'(clip_to(cmd[0], Lim32));
    r.cmd.y = 32'(clip_to(cmd[1], Lim32));
    r.cmd.z = 32'(clip_to(cmd[2], Lim32));

    // Virtual acceleration for the next round
    for (int i = 0; i < 3; i++) begin
      vs = self_st[3 + i];
      virt_accel[i] = clip_to(vel_sum[i] - k * vs + LeaderGain * (lead_st[3 + i] - vs), Lim48);
    end
    r.sat = round_clipped;
    pending_cmds.push_back(r);

    for (int i = 0; i < 3; i++) vel_sum[i] = 0;
    pos_sum[0] = 0;
    pos_sum[1] = 0;
    nbr_count = 0;
    round_clipped = 1'b0;
  endfunction

  function automatic int draw_wait();
    case (idle_level)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 16)) : 0;
      default:    return int'($urandom_range(0, 16));
    endcase
  endfunction

  // Mostly moderate Q16.16 values, some full range and some extremes
  function automatic logic [31:0] draw_q16();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 32'($urandom_range(0, 32'h001f_ffff)) - 32'h0010_0000;
      6, 7:             return 32'($urandom);
      8:                return 32'($urandom_range(0, 32'h07ff_ffff)) - 32'h0400_0000;
      default: begin
        case ($urandom_range(0, 4))
          0:       return QMin;
          1:       return QMax;
          2:       return 32'd0;
          3:       return 32'hffff_ffff;
          default: return 32'd1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] draw_reg16();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void check_field(string label, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", label, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_agent(input logic [3:0] idx, input logic last, input fill_e fill);
    feed_entry_t e;
    e = '0;
    e.word.agent_index = idx;
    e.last = last;
    case (fill)
      FILL_RANDOM: begin
        {e.word.off_y, e.word.off_x, e.word.vel_z, e.word.vel_y} =
          {draw_q16(), draw_q16(), draw_q16(), draw_q16()};
        {e.word.vel_x, e.word.pos_z, e.word.pos_y, e.word.pos_x} =
          {draw_q16(), draw_q16(), draw_q16(), draw_q16()};
      end
      FILL_MAX: begin
        {e.word.off_y, e.word.off_x, e.word.vel_z, e.word.vel_y,
         e.word.vel_x, e.word.pos_z, e.word.pos_y, e.word.pos_x} = {8{QMax}};
      end
      FILL_MIN: begin
        {e.word.off_y, e.word.off_x, e.word.vel_z, e.word.vel_y,
         e.word.vel_x, e.word.pos_z, e.word.pos_y, e.word.pos_x} = {8{QMin}};
      end
      FILL_RUNAWAY: begin
        // drive the neighbour sums towards their upper bound
        {e.word.off_y, e.word.off_x} = {2{QMin}};
        {e.word.vel_z, e.word.vel_y, e.word.vel_x, e.word.pos_z, e.word.pos_y,
         e.word.pos_x} = {6{QMax}};
      end
      default: ;
    endcase
    agent_feed.push_back(e);
    queued_count++;
  endtask

  // One control round: mostly complete rounds in random order, some broken
  // ones, and now and then one long enough to clip the neighbour count
  task automatic queue_random_round(output int n);
    int          pick [$];
    int          kind;
    logic [3:0]  k;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      for (int i = 0; i < MaxAgents; i++)
        if ($urandom_range(0, 9) < ((i == cfg_self || i == 0) ? 9 : 5))
          pick.insert($urandom_range(0, pick.size()), i);
    end else if (kind < 19) begin
      repeat ($urandom_range(1, 8)) pick.push_back($urandom_range(0, MaxAgents - 1));
    end else begin
      repeat ($urandom_range(33, 40)) begin
        k = 4'($urandom_range(1, MaxAgents - 1));
        if (cfg_mask[15:1] != 15'd0)
          while (!cfg_mask[k]) k = 4'($urandom_range(1, MaxAgents - 1));
        pick.push_back(k);
      end
    end
    if (pick.size() == 0) pick.push_back(cfg_self);
    foreach (pick[i]) push_agent(4'(pick[i]), i == pick.size() - 1, FILL_RANDOM);
    n = pick.size();
  endtask

  task automatic wait_idle();
    while (accepted_count != queued_count || pending_cmds.size() != 0) @(posedge clk_i);
    // let the round-end sequence wind down before touching registers
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SELF_INDEX:     cfg_self = val[3:0];
      CFG_NEIGHBOUR_MASK: cfg_mask = val;
      CFG_TIME_STEP:      cfg_dt = val;
      default: ;
    endcase
  endtask

  // Source: present queued agents, advance the model on each transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tlast  <= 1'b0;
      s_axis_tdata  <= '0;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_formation(agent_word_t'(s_axis_tdata), s_axis_tlast);
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (agent_feed.size() > 0) begin
          tx_next = agent_feed.pop_front();
          s_axis_tdata  <= tx_next.word;
          s_axis_tlast  <= tx_next.last;
          s_axis_tvalid <= 1'b1;
          tx_gap = draw_wait();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink: random back-pressure, one long hold on request, compare commands
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rx_got = m_axis_tdata;
        if (pending_cmds.size() == 0) begin
          $error("unexpected command x %0d y %0d z %0d", rx_got.x, rx_got.y, rx_got.z);
          mismatches++;
        end else begin
          rx_want = pending_cmds.pop_front();
          check_field("cmd_vel_x", rx_want.cmd.x, rx_got.x);
          check_field("cmd_vel_y", rx_want.cmd.y, rx_got.y);
          check_field("cmd_vel_z", rx_want.cmd.z, rx_got.z);
          check_field("saturated", {31'd0, rx_want.sat}, {31'd0, m_axis_tuser});
        end
        rx_wait = draw_wait();
      end
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        rx_wait = LongHold;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int         fed;
    int         n;
    logic [3:0] self_pick;
    for (int i = 0; i < 3; i++) begin
      virt_accel[i] = 0;
      vel_sum[i] = 0;
    end
    for (int i = 0; i < 8; i++) begin
      self_st[i] = 0;
      lead_st[i] = 0;
    end
    pos_sum[0] = 0;
    pos_sum[1] = 0;
    nbr_count = 0;
    round_clipped = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: nothing latched yet, then self and leader in one item
    push_agent(4'd7, 1'b1, FILL_MAX);
    push_agent(4'd0, 1'b1, FILL_MIN);
    wait_idle();

    // Upper data bits of the self index are dropped; index 3 is no register
    write_register(CFG_SELF_INDEX, 16'hfff3);
    write_register(CFG_NEIGHBOUR_MASK, 16'hffff);
    write_register(CFG_TIME_STEP, 16'hffff);
    write_register(CfgNoReg, 16'h0005);
    // extremes, a masked leader, the masked self sent twice, closed by another agent
    push_agent(4'd3, 1'b0, FILL_MAX);
    push_agent(4'd0, 1'b0, FILL_MIN);
    push_agent(4'd1, 1'b0, FILL_MAX);
    push_agent(4'd2, 1'b0, FILL_ZERO);
    push_agent(4'd3, 1'b0, FILL_MIN);
    push_agent(4'd15, 1'b1, FILL_RANDOM);
    // self and leader missing, one neighbour repeated
    push_agent(4'd5, 1'b0, FILL_RANDOM);
    push_agent(4'd5, 1'b0, FILL_RANDOM);
    push_agent(4'd9, 1'b1, FILL_RANDOM);
    // round closed on the self item alone
    push_agent(4'd3, 1'b1, FILL_RANDOM);
    wait_idle();

    write_register(CFG_SELF_INDEX, 16'habc0);
    write_register(CFG_NEIGHBOUR_MASK, 16'h0007);
    write_register(CFG_TIME_STEP, 16'h0000);
    push_agent(4'd2, 1'b0, FILL_RANDOM);
    push_agent(4'd1, 1'b0, FILL_RANDOM);
    push_agent(4'd0, 1'b1, FILL_RANDOM);
    wait_idle();

    // Random phases, each under its own register settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          self_pick = 4'd15;
          cfg_mask = 16'hffff;
          cfg_dt = 16'hffff;
          idle_level = IDLE_HEAVY;
        end
        1: begin
          self_pick = 4'd0;
          cfg_mask = 16'h0000;
          cfg_dt = 16'h0000;
          idle_level = IDLE_NONE;
        end
        default: begin
          self_pick = 4'($urandom_range(0, 15));
          cfg_mask = draw_reg16();
          cfg_dt = draw_reg16();
          idle_level = (p == 2) ? IDLE_NONE : idle_mode_e'(p % 3);
        end
      endcase
      write_register(CFG_TIME_STEP, cfg_dt);
      write_register(CFG_NEIGHBOUR_MASK, cfg_mask);
      write_register(CFG_SELF_INDEX, (16'($urandom) & 16'hfff0) | {12'd0, self_pick});
      if ($urandom_range(0, 1) == 1) write_register(CfgNoReg, 16'($urandom));

      // Clip the neighbour sums with one very long round
      if (p == 0) begin
        repeat (270) push_agent(4'($urandom_range(1, 14)), 1'b0, FILL_RUNAWAY);
        push_agent(4'd15, 1'b1, FILL_RANDOM);
      end
      // Stall the sink for a long stretch while the source keeps offering
      if (p == 2) long_hold_req = 1'b1;

      fed = 0;
      while (fed < 150) begin
        queue_random_round(n);
        fed += n;
      end
      wait_idle();
    end

    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/fvc_pkg.sv
hw/rtl/fvc_ctrl.sv
hw/rtl/fvc_dpath.sv
hw/rtl/formation_velocity_consensus.sv
hw/rtl/fvc_checker.sv
test/testbench.sv
